// ----- src/tcp_flow_tracker_top_assert.svh -----
// Assertion macros for the TCP flow tracker.
// Used by tcp_flow_tracker_top; depends on nothing else.
`ifndef TCP_FLOW_TRACKER_TOP_ASSERT_SVH
`define TCP_FLOW_TRACKER_TOP_ASSERT_SVH

// same-cycle implication
`define TFT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcp_flow_tracker: assertion failed");

// next-cycle implication
`define TFT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcp_flow_tracker: assertion failed");

`endif

// ----- src/tft_pkg.sv -----
// Shared types and constants for the TCP flow tracker.
// No dependencies.
package tft_pkg;

    localparam int TFT_ENTRIES_DEF  = 64;
    localparam int TFT_BYTES_DEF    = 48;
    localparam int TFT_WORDS        = 6;

    // TCP flag bit positions
    localparam int FL_FIN = 0;
    localparam int FL_SYN = 1;
    localparam int FL_RST = 2;
    localparam int FL_ACK = 4;

    // flow flag bit positions
    localparam int FF_EST    = 0;
    localparam int FF_TERM   = 1;
    localparam int FF_SYNACK = 2;

    localparam logic       OP_PACKET = 1'b0;
    localparam logic       OP_READ   = 1'b1;
    localparam logic [2:0] WORD_LAST = 3'd5;

    typedef struct packed {
        logic        op;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq_num;
        logic [7:0]  tcp_flags;
        logic [15:0] payload_len;
        logic [5:0]  read_slot;
    } t_in_beat;

    typedef struct packed {
        logic        duplicate;
        logic [5:0]  slot;
        logic        new_flow;
        logic        table_full;
        logic        entry_valid;
        logic [2:0]  word_index;
        logic [63:0] read_word;
        logic        last;
    } t_out_beat;

    // priority chain between neighboring cells
    typedef struct packed {
        logic hit_seen;
        logic free_seen;
    } t_chain;

    // update command broadcast to all cells
    typedef struct packed {
        logic        valid;
        logic        alloc;
        logic        fwd;
        logic [7:0]  flags;
        logic [31:0] seq;
        logic [15:0] len;
        logic [15:0] new_id;
    } t_cmd;

endpackage

// ----- src/tft_if.sv -----
// Valid/ready stream interfaces for the TCP flow tracker.
// Depends on tft_pkg.
interface tft_in_if;
    logic              valid;
    logic              ready;
    tft_pkg::t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tft_out_if;
    logic               valid;
    logic               ready;
    tft_pkg::t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/tft_cell.sv -----
// One flow table entry: key compare, priority chain link, local update.
// Depends on tft_pkg.
module tft_cell #(
    parameter int BYTE_BITS = tft_pkg::TFT_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tft_pkg::t_in_beat i_key,
    input  tft_pkg::t_chain   i_chain,
    output tft_pkg::t_chain   o_chain,
    output logic              o_hit,
    output logic              o_fwd,
    output logic              o_free,
    input  tft_pkg::t_cmd     i_cmd,
    input  logic              i_sel,
    output logic              o_dup,
    output logic              o_est,
    output logic              o_used,
    output logic [63:0]       o_words [tft_pkg::TFT_WORDS]
);
    import tft_pkg::*;

    logic                 r_used;
    logic [31:0]          r_ini_ip, r_res_ip, r_exp_f, r_exp_r;
    logic [15:0]          r_ini_p, r_res_p, r_id;
    logic [31:0]          r_pk_f, r_pk_r, r_dp_f, r_dp_r;
    logic [BYTE_BITS-1:0] r_by_f, r_by_r;
    logic [2:0]           r_flags;

    logic                 w_mf, w_mr, w_dup, w_est, w_syn, w_ack, w_go;
    logic [2:0]           n_flags;
    logic [31:0]          w_next_seq;
    logic [BYTE_BITS:0]   w_sum_f, w_sum_r;
    logic [BYTE_BITS-1:0] w_byte_max;

    assign w_mf = r_used && r_ini_ip == i_key.src_ip && r_res_ip == i_key.dst_ip
               && r_ini_p == i_key.src_port && r_res_p == i_key.dst_port;
    assign w_mr = r_used && r_ini_ip == i_key.dst_ip && r_res_ip == i_key.src_ip
               && r_ini_p == i_key.dst_port && r_res_p == i_key.src_port;

    assign o_hit   = !i_chain.hit_seen && (w_mf || w_mr);
    assign o_fwd   = w_mf;
    assign o_free  = !i_chain.free_seen && !r_used;
    assign o_chain = '{hit_seen: i_chain.hit_seen || w_mf || w_mr,
                       free_seen: i_chain.free_seen || !r_used};
    assign o_used  = r_used;

    assign w_syn      = i_cmd.flags[FL_SYN];
    assign w_ack      = i_cmd.flags[FL_ACK];
    assign w_go       = i_sel && i_cmd.valid;
    assign w_dup      = i_cmd.fwd ? (i_cmd.seq < r_exp_f) : (i_cmd.seq < r_exp_r);
    assign w_next_seq = i_cmd.seq + 32'(i_cmd.len);
    assign w_byte_max = '1;
    assign w_sum_f    = {1'b0, r_by_f} + (BYTE_BITS+1)'(i_cmd.len);
    assign w_sum_r    = {1'b0, r_by_r} + (BYTE_BITS+1)'(i_cmd.len);

    always_comb begin
        n_flags = r_flags;
        if (!n_flags[FF_EST] && w_syn && w_ack) n_flags[FF_SYNACK] = 1'b1;
        w_est = n_flags[FF_SYNACK] && w_ack && !w_syn;
        if (w_est) begin
            n_flags[FF_EST]    = 1'b1;
            n_flags[FF_SYNACK] = 1'b0;
        end
        if (i_cmd.flags[FL_FIN] || i_cmd.flags[FL_RST]) n_flags[FF_TERM] = 1'b1;
    end

    assign o_dup = w_go && !i_cmd.alloc && w_dup;
    assign o_est = w_go && !i_cmd.alloc && w_est;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (w_go && i_cmd.alloc) begin
            r_used <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && i_cmd.alloc) begin
            r_ini_ip <= i_key.src_ip;
            r_res_ip <= i_key.dst_ip;
            r_ini_p  <= i_key.src_port;
            r_res_p  <= i_key.dst_port;
            r_exp_f  <= w_next_seq;
            r_exp_r  <= '0;
            r_pk_f   <= 32'd1;
            r_pk_r   <= '0;
            r_by_f   <= BYTE_BITS'(i_cmd.len);
            r_by_r   <= '0;
            r_dp_f   <= '0;
            r_dp_r   <= '0;
            r_flags  <= '0;
            r_id     <= '0;
        end else if (w_go) begin
            r_flags <= n_flags;
            if (w_est) r_id <= i_cmd.new_id;
            if (i_cmd.fwd) begin
                if (w_dup) begin
                    if (r_dp_f != '1) r_dp_f <= r_dp_f + 32'd1;
                end else begin
                    r_exp_f <= w_next_seq;
                end
                r_by_f <= w_sum_f[BYTE_BITS] ? w_byte_max : w_sum_f[BYTE_BITS-1:0];
                if (r_pk_f != '1) r_pk_f <= r_pk_f + 32'd1;
            end else begin
                if (w_dup) begin
                    if (r_dp_r != '1) r_dp_r <= r_dp_r + 32'd1;
                end else begin
                    r_exp_r <= w_next_seq;
                end
                r_by_r <= w_sum_r[BYTE_BITS] ? w_byte_max : w_sum_r[BYTE_BITS-1:0];
                if (r_pk_r != '1) r_pk_r <= r_pk_r + 32'd1;
            end
        end
    end

    assign o_words[0] = {r_ini_ip, r_res_ip};
    assign o_words[1] = {r_ini_p, r_res_p, r_id, 13'd0, r_flags};
    assign o_words[2] = {r_pk_f, r_pk_r};
    assign o_words[3] = 64'(r_by_f);
    assign o_words[4] = 64'(r_by_r);
    assign o_words[5] = {r_dp_f, r_dp_r};

endmodule

// ----- src/tcp_flow_tracker_top.sv -----
// TCP flow tracker top: sequencer, row of entry cells, result register.
// Depends on tft_pkg, tft_if, tft_cell, tcp_flow_tracker_top_assert.svh.
//
//  port    dir  role                         beat
//  i_in    in   header or readout request    one t_in_beat
//  o_out   out  packet result / entry words  one t_out_beat
//
// A packet is accepted, compared across the cell row with the priority chain,
// then read-modify-written in the selected cell. A read is accepted, then
// streams one word per cycle out of the selected cell while the output has room.
// Synchronous active-low reset clears the used bits, the sequencer, the
// result valid and sets the next flow id to one; no clearing pass.
// Output stalls hold the sequencer before it overwrites the result register.
`include "tcp_flow_tracker_top_assert.svh"
module tcp_flow_tracker_top #(
    parameter int TABLE_ENTRIES   = tft_pkg::TFT_ENTRIES_DEF,
    parameter int BYTE_COUNT_BITS = tft_pkg::TFT_BYTES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tft_in_if.sink   i_in,
    tft_out_if.source o_out
);
    import tft_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MATCH = 2'd1;
    localparam logic [1:0] S_UPD   = 2'd2;
    localparam logic [1:0] S_RDW   = 2'd3;

    logic [1:0]  r_state, n_state;
    t_in_beat    r_item;
    t_out_beat   r_out;
    logic        r_ov, n_ov;
    logic [15:0] r_next_id;
    logic [2:0]  r_widx;

    // match results, registered
    logic [TABLE_ENTRIES-1:0] r_sel;
    logic                     r_any_hit, r_any_free, r_fwd;
    logic [IW-1:0]            r_idx;

    t_chain                   w_chain [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] w_hit, w_free, w_fwd, w_dup, w_est, w_used;
    logic [63:0]              w_words [TABLE_ENTRIES][TFT_WORDS];
    logic [IW-1:0]            w_hit_idx, w_free_idx, w_rd_idx;
    logic                     w_in_fire, w_out_fire, w_space, w_rd_ok;
    t_cmd                     w_cmd;

    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_fire = o_out.valid && o_out.ready;
    assign w_space    = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    // result register loads in the update or word steps; otherwise drains on a beat
    assign n_ov = ((r_state == S_UPD || r_state == S_RDW) && w_space) ? 1'b1
                : (r_ov && !w_out_fire);

    assign w_chain[0] = '{hit_seen: 1'b0, free_seen: 1'b0};

    // update command, driven only in the update step with room at the output
    assign w_cmd = '{valid: (r_state == S_UPD) && w_space && (r_any_hit || r_any_free),
                     alloc: !r_any_hit, fwd: r_fwd, flags: r_item.tcp_flags,
                     seq: r_item.seq_num, len: r_item.payload_len, new_id: r_next_id};

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            tft_cell #(.BYTE_BITS(BYTE_COUNT_BITS)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_key   (r_item),
                .i_chain (w_chain[g]),
                .o_chain (w_chain[g+1]),
                .o_hit   (w_hit[g]),
                .o_fwd   (w_fwd[g]),
                .o_free  (w_free[g]),
                .i_cmd   (w_cmd),
                .i_sel   (r_sel[g]),
                .o_dup   (w_dup[g]),
                .o_est   (w_est[g]),
                .o_used  (w_used[g]),
                .o_words (w_words[g])
            );
        end
    endgenerate

    // one-hot to index
    always_comb begin
        w_hit_idx  = '0;
        w_free_idx = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (w_hit[i])  w_hit_idx  = w_hit_idx  | IW'(i);
            if (w_free[i]) w_free_idx = w_free_idx | IW'(i);
        end
    end

    assign w_rd_idx = IW'(r_item.read_slot);
    assign w_rd_ok  = (32'(r_item.read_slot) < 32'(TABLE_ENTRIES)) && w_used[w_rd_idx];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_fire) n_state = (i_in.data.op == OP_READ) ? S_RDW : S_MATCH;
            S_MATCH: n_state = S_UPD;
            S_UPD:   if (w_space) n_state = S_IDLE;
            S_RDW:   if (w_space && r_widx == WORD_LAST) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ov      <= 1'b0;
            r_next_id <= 16'd1;
            r_widx    <= '0;
            r_sel     <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            if (w_in_fire) r_widx <= '0;
            case (r_state)
                S_MATCH: begin
                    r_sel <= (w_chain[TABLE_ENTRIES].hit_seen) ? w_hit
                           : w_free;
                end
                S_UPD: begin
                    if (w_space) begin
                        r_sel <= '0;
                        if (|w_est) r_next_id <= (r_next_id == 16'hFFFF) ? 16'd1
                                                                         : r_next_id + 16'd1;
                    end
                end
                S_RDW: begin
                    if (w_space) begin
                        r_widx <= r_widx + 3'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) r_item <= i_in.data;
        if (r_state == S_MATCH) begin
            r_any_hit  <= w_chain[TABLE_ENTRIES].hit_seen;
            r_any_free <= w_chain[TABLE_ENTRIES].free_seen;
            r_fwd      <= |(w_hit & w_fwd);
            r_idx      <= w_chain[TABLE_ENTRIES].hit_seen ? w_hit_idx : w_free_idx;
        end
        if (r_state == S_UPD && w_space) begin
            r_out.duplicate   <= |w_dup;
            r_out.slot        <= (r_any_hit || r_any_free) ? 6'(r_idx) : 6'd0;
            r_out.new_flow    <= !r_any_hit && r_any_free;
            r_out.table_full  <= !r_any_hit && !r_any_free;
            r_out.entry_valid <= r_any_hit || r_any_free;
            r_out.word_index  <= '0;
            r_out.read_word   <= '0;
            r_out.last        <= 1'b1;
        end else if (r_state == S_RDW && w_space) begin
            r_out.duplicate   <= 1'b0;
            r_out.slot        <= r_item.read_slot;
            r_out.new_flow    <= 1'b0;
            r_out.table_full  <= 1'b0;
            r_out.entry_valid <= w_rd_ok;
            r_out.word_index  <= r_widx;
            r_out.read_word   <= w_rd_ok ? w_words[w_rd_idx][r_widx] : 64'd0;
            r_out.last        <= (r_widx == WORD_LAST);
        end
    end

    `TFT_ASSERT_NOW(a_sel_onehot, i_clk, i_rst_n, 1'b1, $onehot0(r_sel))
    `TFT_ASSERT_NOW(a_id_nonzero, i_clk, i_rst_n, 1'b1, r_next_id != 16'd0)
    `TFT_ASSERT_NOW(a_full_clean, i_clk, i_rst_n, r_ov && r_out.table_full, !r_out.entry_valid && !r_out.new_flow)
    `TFT_ASSERT_NXT(a_upd_result, i_clk, i_rst_n, r_state == S_UPD && w_space, r_ov && r_out.last)

endmodule

// ----- dv/tft_test_pkg.sv -----
`timescale 1ns / 100ps
// Expected-result model of the TCP flow tracker table for the testbench.
// Depends on tft_pkg.
package tft_test_pkg;
    import tft_pkg::*;

    localparam int NUM_SLOTS = 64;
    localparam int BYTE_BITS = 48;

    typedef struct {
        bit          used;
        bit [31:0]   init_ip, resp_ip;
        bit [15:0]   init_port, resp_port;
        bit [31:0]   next_seq_fwd, next_seq_rev;
        bit [63:0]   pkts, dups;
        bit [63:0]   bytes_f, bytes_r;
        bit [2:0]    fflags;
        bit [15:0]   id;
    } flow_rec_t;

    class flow_table;
        flow_rec_t   tbl[NUM_SLOTS];
        bit [15:0]   id_next;
        t_out_beat   results[$];

        function void clear();
            foreach (tbl[k]) tbl[k] = '{default: 0};
            id_next = 16'd1;
            results.delete();
        endfunction

        function bit [63:0] add_bytes(bit [63:0] cur, bit [15:0] len);
            bit [63:0] lim;
            lim = (64'd1 << BYTE_BITS) - 1;
            if (cur > lim) cur = lim;
            if (64'(len) > lim - cur) return lim;
            return cur + 64'(len);
        endfunction

        function bit [63:0] bump(bit [63:0] w, bit hi);
            bit [31:0] h;
            h = hi ? w[63:32] : w[31:0];
            if (h != 32'hFFFF_FFFF) h++;
            if (hi) w[63:32] = h; else w[31:0] = h;
            return w;
        endfunction

        function void push(bit d, bit [5:0] s, bit nf, bit full, bit v, bit [2:0] wi,
                           bit [63:0] w, bit l);
            t_out_beat r;
            r.duplicate = d; r.slot = s; r.new_flow = nf; r.table_full = full;
            r.entry_valid = v; r.word_index = wi; r.read_word = w; r.last = l;
            results.push_back(r);
        endfunction

        function void apply(t_in_beat b);
            int hit, free_idx;
            bit fwd, dup;
            bit [63:0] w[6];
            bit [2:0] f;
            hit = -1; free_idx = -1; fwd = 1; dup = 0;
            if (b.op == OP_READ) begin
                foreach (w[k]) w[k] = 0;
                if (tbl[b.read_slot].used) begin
                    w[0] = {tbl[b.read_slot].init_ip, tbl[b.read_slot].resp_ip};
                    w[1] = {tbl[b.read_slot].init_port, tbl[b.read_slot].resp_port,
                            tbl[b.read_slot].id, 13'd0, tbl[b.read_slot].fflags};
                    w[2] = tbl[b.read_slot].pkts;
                    w[3] = tbl[b.read_slot].bytes_f;
                    w[4] = tbl[b.read_slot].bytes_r;
                    w[5] = tbl[b.read_slot].dups;
                end
                for (int k = 0; k < TFT_WORDS; k++)
                    push(0, b.read_slot, 0, 0, tbl[b.read_slot].used, k[2:0], w[k],
                         k[2:0] == WORD_LAST);
                return;
            end
            for (int k = 0; k < NUM_SLOTS; k++) begin
                if (!tbl[k].used) begin
                    if (free_idx < 0) free_idx = k;
                    continue;
                end
                if (tbl[k].init_ip == b.src_ip && tbl[k].resp_ip == b.dst_ip &&
                    tbl[k].init_port == b.src_port && tbl[k].resp_port == b.dst_port) begin
                    hit = k; fwd = 1; break;
                end
                if (tbl[k].init_ip == b.dst_ip && tbl[k].resp_ip == b.src_ip &&
                    tbl[k].init_port == b.dst_port && tbl[k].resp_port == b.src_port) begin
                    hit = k; fwd = 0; break;
                end
            end
            if (hit < 0) begin
                if (free_idx < 0) begin
                    push(0, 0, 0, 1, 0, 0, 0, 1);
                    return;
                end
                tbl[free_idx] = '{used: 1, init_ip: b.src_ip, resp_ip: b.dst_ip,
                    init_port: b.src_port, resp_port: b.dst_port,
                    next_seq_fwd: b.seq_num + 32'(b.payload_len), next_seq_rev: 0,
                    pkts: 64'd1 << 32, dups: 0, bytes_f: add_bytes(0, b.payload_len),
                    bytes_r: 0, fflags: 0, id: 0};
                push(0, free_idx[5:0], 1, 0, 1, 0, 0, 1);
                return;
            end
            f = tbl[hit].fflags;
            if (!f[FF_EST] && b.tcp_flags[FL_SYN] && b.tcp_flags[FL_ACK]) f[FF_SYNACK] = 1;
            if (f[FF_SYNACK] && b.tcp_flags[FL_ACK] && !b.tcp_flags[FL_SYN]) begin
                f[FF_EST] = 1; f[FF_SYNACK] = 0;
                tbl[hit].id = id_next;
                id_next = (id_next == 16'hFFFF) ? 16'd1 : id_next + 16'd1;
            end
            if (b.tcp_flags[FL_FIN] || b.tcp_flags[FL_RST]) f[FF_TERM] = 1;
            tbl[hit].fflags = f;
            if (fwd) begin
                if (b.seq_num < tbl[hit].next_seq_fwd) begin
                    dup = 1; tbl[hit].dups = bump(tbl[hit].dups, 1);
                end else tbl[hit].next_seq_fwd = b.seq_num + 32'(b.payload_len);
                tbl[hit].bytes_f = add_bytes(tbl[hit].bytes_f, b.payload_len);
                tbl[hit].pkts = bump(tbl[hit].pkts, 1);
            end else begin
                if (b.seq_num < tbl[hit].next_seq_rev) begin
                    dup = 1; tbl[hit].dups = bump(tbl[hit].dups, 0);
                end else tbl[hit].next_seq_rev = b.seq_num + 32'(b.payload_len);
                tbl[hit].bytes_r = add_bytes(tbl[hit].bytes_r, b.payload_len);
                tbl[hit].pkts = bump(tbl[hit].pkts, 0);
            end
            push(dup, hit[5:0], 0, 0, 1, 0, 0, 1);
        endfunction
    endclass
endpackage

// ----- dv/tcp_flow_tracker_top_test.sv -----
`timescale 1ns / 100ps
// Testbench top for tcp_flow_tracker_top: directed and random header/readout beats,
// checked against a table model. Depends on tft_pkg, tft_if and tft_test_pkg.
module tcp_flow_tracker_top_test;
    import tft_pkg::*;
    import tft_test_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tft_in_if  in_ch ();
    tft_out_if out_ch ();

    tcp_flow_tracker_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #4 i_clk = ~i_clk;

    flow_table  model;
    t_in_beat   pending[$];
    int         send_idle_pct;   // chance in 100 that the driver holds off
    int         recv_idle_pct;   // chance in 100 that the monitor stalls
    int         errors, beats_in, beats_out, cycles, beats_offered;
    int         n_pkts, n_reads, n_new, n_dup, n_full;
    bit         started;

    // small address pool so that packets hit stored flows in both directions
    logic [31:0] ip_pool[8];
    logic [15:0] port_pool[8];

    task automatic report(string what, t_out_beat got, t_out_beat want);
        errors++;
        $display("mismatch %s at %0t: got %p want %p", what, $time, got, want);
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // driver: new beats appear at the falling edge only
    always @(negedge i_clk) begin
        if (started) begin
            // nothing on offer, or the offered beat was taken at the last rising edge
            if (beats_in == beats_offered) begin
                if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_ch.valid <= 1'b1;
                    in_ch.data <= pending.pop_front();
                    beats_offered++;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: sample both channels at the rising edge
    always @(posedge i_clk) begin
        t_out_beat got, want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL tcp_flow_tracker_top");
            $finish;
        end
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            beats_in++;
            if (in_ch.data.op == OP_READ) n_reads++; else n_pkts++;
            model.apply(in_ch.data);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            beats_out++;
            if (model.results.size() == 0) begin
                report("unexpected beat", got, '0);
            end else begin
                want = model.results.pop_front();
                if (got.new_flow) n_new++;
                if (got.duplicate) n_dup++;
                if (got.table_full) n_full++;
                if (got.duplicate !== want.duplicate) report("duplicate", got, want);
                if (got.slot !== want.slot) report("slot", got, want);
                if (got.new_flow !== want.new_flow) report("new_flow", got, want);
                if (got.table_full !== want.table_full) report("table_full", got, want);
                if (got.entry_valid !== want.entry_valid) report("entry_valid", got, want);
                if (got.word_index !== want.word_index) report("word_index", got, want);
                if (got.read_word !== want.read_word) report("read_word", got, want);
                if (got.last !== want.last) report("last", got, want);
            end
        end
    end

    function automatic t_in_beat rand_beat();
        t_in_beat b;
        b.op = OP_PACKET;
        b.src_ip = $urandom(); b.dst_ip = $urandom();
        b.src_port = 16'($urandom()); b.dst_port = 16'($urandom());
        b.seq_num = $urandom(); b.tcp_flags = 8'($urandom());
        b.payload_len = 16'($urandom()); b.read_slot = 6'($urandom());
        return b;
    endfunction

    function automatic t_in_beat pkt(int a, int c, int s, bit [7:0] fl, bit [15:0] len);
        t_in_beat b;
        b = rand_beat();
        b.src_ip = ip_pool[a]; b.dst_ip = ip_pool[c];
        b.src_port = port_pool[a]; b.dst_port = port_pool[c];
        b.seq_num = s; b.tcp_flags = fl; b.payload_len = len;
        return b;
    endfunction

    function automatic t_in_beat rd(int s);
        t_in_beat b;
        b = rand_beat();
        b.op = OP_READ; b.read_slot = 6'(s);
        return b;
    endfunction

    // one connection: handshake, data both ways, some replays, sometimes a teardown
    task automatic add_session(int a, int c);
        bit [31:0] sa, sc;
        bit [7:0] syn, sack, ack, fin;
        sa = $urandom(); sc = $urandom();
        syn = 8'h1 << FL_SYN; ack = 8'h1 << FL_ACK; sack = syn | ack; fin = 8'h1 << FL_FIN;
        pending.push_back(pkt(a, c, sa, syn, 0));
        pending.push_back(pkt(c, a, sc, sack, 0));
        pending.push_back(pkt(a, c, sa, ack, 0));
        repeat ($urandom_range(4)) begin
            bit [15:0] l;
            l = 16'($urandom_range(1500));
            if ($urandom_range(1)) begin
                pending.push_back(pkt(a, c, sa, ack, l)); sa += l;
            end else begin
                pending.push_back(pkt(c, a, sc, ack, l)); sc += l;
            end
            if ($urandom_range(3) == 0) pending.push_back(pkt(a, c, sa - 1, ack, l));
        end
        if ($urandom_range(1)) pending.push_back(pkt(a, c, sa, fin | ack, 0));
        if ($urandom_range(5) == 0) pending.push_back(rd($urandom_range(63)));
    endtask

    task automatic run_phase(int snd, int rcv, int n);
        send_idle_pct = snd; recv_idle_pct = rcv;
        for (int k = 0; k < n; k++) begin
            int r;
            r = $urandom_range(99);
            if (r < 55) add_session($urandom_range(7), $urandom_range(7));
            else if (r < 75) pending.push_back(rand_beat());
            else if (r < 85) pending.push_back(rd($urandom_range(63)));
            else pending.push_back(pkt($urandom_range(7), $urandom_range(7),
                                       $urandom(), 8'($urandom()), 16'($urandom())));
        end
        while (pending.size() > 0 || in_ch.valid || model.results.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        t_in_beat b;
        model = new();
        model.clear();
        foreach (ip_pool[k]) begin
            ip_pool[k] = $urandom(); port_pool[k] = 16'($urandom());
        end
        ip_pool[0] = '0; port_pool[0] = '0;
        ip_pool[1] = '1; port_pool[1] = '1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        started = 1'b1;

        // directed: extremes, handshake both ways, wrap of seq
        send_idle_pct = 0; recv_idle_pct = 0;
        pending.push_back(rd(0));                               // unused entry
        pending.push_back(pkt(0, 1, 32'hFFFF_FFFF, 8'h00, 16'hFFFF)); // expected seq wraps
        pending.push_back(pkt(1, 0, 0, 8'h12, 16'hFFFF));       // reverse SYN+ACK
        pending.push_back(pkt(0, 1, 32'hFFFF_FFFE, 8'h10, 0));  // ACK: establish
        pending.push_back(pkt(0, 1, 0, 8'hFF, 16'hFFFF));       // all flags
        pending.push_back(pkt(1, 0, 0, 8'h04, 0));              // RST, reverse dup
        pending.push_back(rd(0));
        b = pkt(0, 0, 5, 8'h00, 1);                             // self flow, fwd wins
        pending.push_back(b); pending.push_back(b);
        pending.push_back(rd(1));
        pending.push_back(rd(63));
        while (pending.size() > 0 || in_ch.valid || model.results.size() > 0)
            @(posedge i_clk);

        // fill the table to reach the full flag, then read back every ninth entry and the last
        for (int k = 0; k < NUM_SLOTS + 2; k++) pending.push_back(rand_beat());
        for (int k = 0; k < NUM_SLOTS; k += 9) pending.push_back(rd(k));
        pending.push_back(rd(63));
        while (pending.size() > 0 || in_ch.valid || model.results.size() > 0)
            @(posedge i_clk);

        // table stays full from here; random phases run against the stored flows
        run_phase(38, 54, 35);
        run_phase(54, 38, 35);
        run_phase(0, 0, 35);

        repeat (50) @(posedge i_clk);
        $display("covered %0d packets, %0d reads, %0d beats out", n_pkts, n_reads, beats_out);
        $display("new flows %0d, duplicates %0d, table full %0d", n_new, n_dup, n_full);
        if (errors == 0 && model.results.size() == 0) begin
            $display("PASS tcp_flow_tracker_top");
        end else begin
            $display("FAIL tcp_flow_tracker_top");
        end
        $finish;
    end
endmodule
